FILE: rtl/ffea_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and codes for the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BADFREE = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,
    S_ACHK,
    S_FRD,
    S_FCHK,
    S_SRD,
    S_SCHK,
    S_PRD,
    S_PCHK,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/first_fit_extent_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_core
// First-fit free-extent allocator with coalescing on free.
// ----------------------------------------------------------------------------
// One command word is taken when start is high and busy is low; its result
// word appears for exactly one cycle with done high and must be taken then.
// An allocate or a free walks the address-ordered list held in one
// single-port-read extent memory, visiting each extent with a read state
// and then a check state; a clear, an unknown command or a free rejected
// up front goes straight to the done state. Free slots are found from a
// bitmap of slot-use flags held in flip-flops with a priority pick. Writes
// to the memory are made one per cycle; a read always follows the last
// write to that entry so no forwarding is needed. Links of unused entries
// are never followed, so only slot 0 needs a value after reset: it is
// written with the full default pool while reset is held.
module first_fit_extent_allocator_core #(
  parameter int MAX_EXTENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] req_size,
  input  wire logic [31:0] req_offset,
  output logic             done,
  output logic [2:0]       status,
  output logic [31:0]      granted_offset,
  output logic [31:0]      free_bytes,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  localparam int Aw = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int Dw = 65 + Aw;
  localparam int Cw = $clog2(MAX_EXTENTS + 1);

  ffea_pkg::state_t state, state_next;

  logic [31:0] pool_bytes;
  logic [MAX_EXTENTS-1:0] in_use;
  logic [Aw-1:0] head_slot;
  logic          list_nonempty;
  logic [31:0]   free_total;

  logic [31:0] c_size, c_off;
  logic [Aw-1:0] cur, prev;
  logic        have_prev, have_succ;
  logic [Cw-1:0] steps;
  // Saved extents: prev and successor contents.
  logic [31:0] p_start, p_len, s_start, s_len;
  logic [Aw-1:0] p_link, s_link;
  logic        p_hn, s_hn;
  logic [Aw-1:0] new_slot;

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [Dw-1:0] wdata, rdata;

  ffea_mem #(.Depth(MAX_EXTENTS), .Aw(Aw)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] r_start, r_len;
  logic [Aw-1:0] r_link;
  logic        r_hn;
  assign r_start = rdata[Dw-1 -: 32];
  assign r_len   = rdata[Dw-33 -: 32];
  assign r_link  = rdata[Aw:1];
  assign r_hn    = rdata[0];

  // Lowest unused slot.
  logic          slot_found;
  logic [Aw-1:0] slot_pick;
  always_comb begin
    slot_found = 1'b0;
    slot_pick = '0;
    for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        slot_found = 1'b1;
        slot_pick = Aw'(i);
      end
    end
  end

  logic [32:0] end33, sum33;
  assign end33 = {1'b0, c_off} + {1'b0, c_size};

  logic walk_last;
  assign walk_last = (steps == Cw'(MAX_EXTENTS - 1));

  // Free merge arithmetic.
  logic        merge_s, merge_p;
  logic [32:0] s_merge_len, p_merge_len;
  logic [31:0] n_len, n_len_sat;
  logic [Aw-1:0] n_link;
  logic        n_hn;
  always_comb begin
    merge_s = have_succ && (end33[31:0] == s_start);
    s_merge_len = {1'b0, s_start} + {1'b0, s_len} - {1'b0, c_off};
    n_len  = merge_s ? (s_merge_len[32] ? 32'hFFFF_FFFF : s_merge_len[31:0]) : c_size;
    n_link = merge_s ? s_link : (have_succ ? cur : '0);
    n_hn   = merge_s ? s_hn : have_succ;
    merge_p = have_prev && (({1'b0, p_start} + {1'b0, p_len}) == {1'b0, c_off});
    p_merge_len = {1'b0, c_off} + {1'b0, n_len} - {1'b0, p_start};
    n_len_sat = p_merge_len[32] ? 32'hFFFF_FFFF : p_merge_len[31:0];
  end

  assign sum33 = {1'b0, free_total} + {1'b0, c_size};

  logic free_past_end;
  assign free_past_end = ({1'b0, req_offset} + {1'b0, req_size}) > 33'h0_FFFF_FFFF;

  always_comb begin
    state_next = state;
    case (state)
      ffea_pkg::S_IDLE: begin
        if (start) begin
          case (cmd)
            ffea_pkg::CMD_ALLOC: state_next = list_nonempty ? ffea_pkg::S_ARD
                                                            : ffea_pkg::S_DONE;
            ffea_pkg::CMD_FREE: begin
              if (req_size == '0 || free_past_end)
                state_next = ffea_pkg::S_DONE;
              else
                state_next = list_nonempty ? ffea_pkg::S_FRD : ffea_pkg::S_SCHK;
            end
            default: state_next = ffea_pkg::S_DONE;
          endcase
        end
      end
      ffea_pkg::S_ARD:  state_next = ffea_pkg::S_ACHK;
      ffea_pkg::S_ACHK: begin
        if (r_len >= c_size || !r_hn || walk_last) state_next = ffea_pkg::S_DONE;
        else state_next = ffea_pkg::S_ARD;
      end
      ffea_pkg::S_FRD:  state_next = ffea_pkg::S_FCHK;
      ffea_pkg::S_FCHK: begin
        if (r_start >= c_off || !r_hn || walk_last) begin
          if (r_start == c_off) state_next = ffea_pkg::S_DONE;
          else state_next = ffea_pkg::S_SCHK;
        end else begin
          state_next = ffea_pkg::S_FRD;
        end
      end
      ffea_pkg::S_SCHK: state_next = slot_found ? ffea_pkg::S_PRD : ffea_pkg::S_DONE;
      ffea_pkg::S_PRD:  state_next = ffea_pkg::S_PCHK;
      ffea_pkg::S_PCHK: state_next = ffea_pkg::S_DONE;
      ffea_pkg::S_DONE: state_next = ffea_pkg::S_IDLE;
      default:          state_next = ffea_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != ffea_pkg::S_IDLE);
  assign cfg_ready = (state == ffea_pkg::S_IDLE);
  assign done = (state == ffea_pkg::S_DONE);
  assign raddr = cur;

  // Memory write port, one write per cycle. While reset is held, slot 0 is
  // loaded with the single extent that covers the default pool.
  always_comb begin
    we = 1'b0;
    waddr = cur;
    wdata = '0;
    case (state)
      ffea_pkg::S_IDLE: begin
        if (start && cmd == ffea_pkg::CMD_CLEAR) begin
          we = 1'b1;
          waddr = '0;
          wdata = {32'd0, pool_bytes, {Aw{1'b0}}, 1'b0};
        end
      end
      ffea_pkg::S_ACHK: begin
        if (r_len > c_size) begin
          we = 1'b1;
          wdata = {r_start + c_size, r_len - c_size, r_link, r_hn};
        end else if (r_len == c_size && have_prev) begin
          we = 1'b1;
          waddr = prev;
          wdata = {p_start, p_len, r_link, r_hn};
        end
      end
      ffea_pkg::S_SCHK: begin
        if (slot_found) begin
          we = 1'b1;
          waddr = slot_pick;
          wdata = {c_off, n_len, n_link, n_hn};
        end
      end
      ffea_pkg::S_PCHK: begin
        if (have_prev) begin
          we = 1'b1;
          waddr = prev;
          if (merge_p) wdata = {p_start, n_len_sat, n_link, n_hn};
          else         wdata = {p_start, p_len, new_slot, 1'b1};
        end
      end
      default: ;
    endcase
    if (rst) begin
      we = 1'b1;
      waddr = '0;
      wdata = {32'd0, 32'd65536, {Aw{1'b0}}, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffea_pkg::S_IDLE;
      pool_bytes <= 32'd65536;
      in_use <= MAX_EXTENTS'(1);
      head_slot <= '0;
      list_nonempty <= 1'b1;
      free_total <= 32'd65536;
      status <= ffea_pkg::ST_OK;
      granted_offset <= '0;
      cur <= '0;
      prev <= '0;
      have_prev <= 1'b0;
      have_succ <= 1'b0;
      steps <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) pool_bytes <= cfg_data;
      case (state)
        ffea_pkg::S_IDLE: begin
          c_size <= req_size;
          c_off <= req_offset;
          cur <= head_slot;
          have_prev <= 1'b0;
          have_succ <= 1'b0;
          steps <= '0;
          granted_offset <= '0;
          if (start && cmd == ffea_pkg::CMD_ALLOC && !list_nonempty)
            status <= ffea_pkg::ST_NOFIT;
          else if (start && cmd == ffea_pkg::CMD_FREE && req_size == '0)
            status <= ffea_pkg::ST_ZERO;
          else if (start && cmd == ffea_pkg::CMD_FREE && free_past_end)
            status <= ffea_pkg::ST_BADFREE;
          else
            status <= ffea_pkg::ST_OK;
          if (start && cmd == ffea_pkg::CMD_CLEAR) begin
            head_slot <= '0;
            list_nonempty <= (pool_bytes != '0);
            in_use <= {{(MAX_EXTENTS-1){1'b0}}, (pool_bytes != '0)};
            free_total <= pool_bytes;
          end
        end
        ffea_pkg::S_ACHK: begin
          if (r_len >= c_size) begin
            granted_offset <= r_start;
            free_total <= (free_total >= c_size) ? free_total - c_size : '0;
            if (r_len == c_size) begin
              in_use[cur] <= 1'b0;
              if (!have_prev) begin
                if (r_hn) head_slot <= r_link;
                else list_nonempty <= 1'b0;
              end
            end
          end else if (!r_hn || walk_last) begin
            status <= ffea_pkg::ST_NOFIT;
          end else begin
            prev <= cur;
            have_prev <= 1'b1;
            p_start <= r_start;
            p_len <= r_len;
            cur <= r_link;
            steps <= steps + 1'b1;
          end
        end
        ffea_pkg::S_FCHK: begin
          if (r_start == c_off) begin
            status <= ffea_pkg::ST_BADFREE;
          end else if (r_start > c_off) begin
            have_succ <= 1'b1;
            s_start <= r_start;
            s_len <= r_len;
            s_link <= r_link;
            s_hn <= r_hn;
          end else begin
            prev <= cur;
            have_prev <= 1'b1;
            p_start <= r_start;
            p_len <= r_len;
            if (r_hn && !walk_last) begin
              cur <= r_link;
              steps <= steps + 1'b1;
            end
          end
        end
        ffea_pkg::S_SCHK: begin
          if (!slot_found) begin
            status <= ffea_pkg::ST_FULL;
          end else begin
            new_slot <= slot_pick;
            // Claim the new slot and, when it swallows its successor, release that.
            in_use <= (in_use | (MAX_EXTENTS'(1) << slot_pick)) &
                      ~(merge_s ? (MAX_EXTENTS'(1) << cur) : '0);
            if (!have_prev) begin
              head_slot <= slot_pick;
              list_nonempty <= 1'b1;
            end
            free_total <= sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
          end
        end
        ffea_pkg::S_PCHK: begin
          if (merge_p) in_use[new_slot] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign free_bytes = free_total;

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_busy_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted without going busy");
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ffea_pkg::ST_OK) |-> (granted_offset == '0))
    else $error("granted offset set on a failed command");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy)
    else $error("configuration taken while busy");
endmodule
`default_nettype wire

FILE: rtl/ffea_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffea_mem
// Extent table: one synchronous memory of start, length, link and has-next.
// ----------------------------------------------------------------------------
module ffea_mem #(
  parameter int Depth = 64,
  parameter int Aw = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [Aw-1:0] waddr,
  input  wire logic [64+Aw:0] wdata,
  input  wire logic [Aw-1:0] raddr,
  output logic      [64+Aw:0] rdata
);
  logic [64+Aw:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
